[hdl/swv_pkg.sv]
// ----------------------------------------------------------------------------
// swv_pkg
// Shared types and constants of the square wave voltammetry sequencer.
// ----------------------------------------------------------------------------
package swv_pkg;

   // Configuration register indexes.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] REG_START     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_STOP      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_STEP      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_AMPLITUDE = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_LOW       = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_HIGH      = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_QUIET     = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_GAIN      = 3'd7;

   localparam int unsigned GAIN_W     = 24;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd11915;

   // Voltage conversion: 2346 - ((code * 1503) >> 10).
   localparam int unsigned VOLT_W     = 13;
   localparam int unsigned VSCALE_W   = 11;
   localparam logic [VSCALE_W-1:0] VOLT_SCALE = 11'd1503;
   localparam int unsigned VOLT_SHIFT = 10;
   localparam logic signed [31:0] VOLT_OFFSET = 32'sd2346;

   localparam int unsigned DIFF_W     = 32;
   localparam int unsigned DIFF_SHIFT = 16;

   // Input operation codes.
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_QUIET,
      PH_LOW,
      PH_HIGH
   } phase_type;

   // Result flags, dac_write in the lowest bit.
   typedef struct packed {
      logic sweep_done;
      logic point_valid;
      logic busy_res;
      logic dac_write;
   } swv_flags_type;

endpackage

[hdl/swv_cfg.sv]
// ----------------------------------------------------------------------------
// swv_cfg
// Configuration register file, written through the plain csr write port.
// ----------------------------------------------------------------------------
module swv_cfg
   import swv_pkg::*;
#(
   parameter int DAC_BITS   = 12,
   parameter int TIMER_BITS = 16,
   parameter int CSR_W      = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]      csr_wdata,
   output logic [DAC_BITS-1:0]   start_code,
   output logic [DAC_BITS-1:0]   stop_code,
   output logic [DAC_BITS-1:0]   step_code,
   output logic [DAC_BITS-1:0]   amplitude_code,
   output logic [TIMER_BITS-1:0] low_ticks,
   output logic [TIMER_BITS-1:0] high_ticks,
   output logic [TIMER_BITS-1:0] quiet_ticks,
   output logic [GAIN_W-1:0]     current_gain
);

   logic [DAC_BITS-1:0]   start_ff, stop_ff, step_ff, amp_ff;
   logic [TIMER_BITS-1:0] low_ff, high_ff, quiet_ff;
   logic [GAIN_W-1:0]     gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         stop_ff  <= '1;
         step_ff  <= DAC_BITS'(1);
         amp_ff   <= '0;
         low_ff   <= TIMER_BITS'(1);
         high_ff  <= TIMER_BITS'(1);
         quiet_ff <= '0;
         gain_ff  <= GAIN_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            REG_START:     start_ff <= csr_wdata[DAC_BITS-1:0];
            REG_STOP:      stop_ff  <= csr_wdata[DAC_BITS-1:0];
            REG_STEP:      step_ff  <= csr_wdata[DAC_BITS-1:0];
            REG_AMPLITUDE: amp_ff   <= csr_wdata[DAC_BITS-1:0];
            REG_LOW:       low_ff   <= csr_wdata[TIMER_BITS-1:0];
            REG_HIGH:      high_ff  <= csr_wdata[TIMER_BITS-1:0];
            REG_QUIET:     quiet_ff <= csr_wdata[TIMER_BITS-1:0];
            REG_GAIN:      gain_ff  <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   assign start_code     = start_ff;
   assign stop_code      = stop_ff;
   assign step_code      = step_ff;
   assign amplitude_code = amp_ff;
   assign low_ticks      = low_ff;
   assign high_ticks     = high_ff;
   assign quiet_ticks    = quiet_ff;
   assign current_gain   = gain_ff;

endmodule

[hdl/swv_seq.sv]
// ----------------------------------------------------------------------------
// swv_seq
// Sweep sequencer: phase, level and hold timer, plus the point arithmetic.
// State advances on every processed transaction; results are combinational.
// ----------------------------------------------------------------------------
module swv_seq
   import swv_pkg::*;
#(
   parameter int DAC_BITS   = 12,
   parameter int ADC_BITS   = 10,
   parameter int TIMER_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     proc_en,
   input  logic                     operation,
   input  logic [ADC_BITS-1:0]      adc_sample,
   input  logic [DAC_BITS-1:0]      start_code,
   input  logic [DAC_BITS-1:0]      stop_code,
   input  logic [DAC_BITS-1:0]      step_code,
   input  logic [DAC_BITS-1:0]      amplitude_code,
   input  logic [TIMER_BITS-1:0]    low_ticks,
   input  logic [TIMER_BITS-1:0]    high_ticks,
   input  logic [TIMER_BITS-1:0]    quiet_ticks,
   input  logic [GAIN_W-1:0]        current_gain,
   output logic [DAC_BITS-1:0]      dac_code,
   output logic signed [VOLT_W-1:0] step_voltage_mv,
   output logic signed [DIFF_W-1:0] difference_current,
   output swv_flags_type            flags
);

   localparam int VPROD_W = DAC_BITS + VSCALE_W;
   localparam int VQ_W    = VPROD_W - VOLT_SHIFT;
   localparam int DPROD_W = ADC_BITS + 1 + GAIN_W + 1;
   localparam int DQ_W    = DPROD_W - DIFF_SHIFT;

   phase_type             phase_ff, phase_in;
   logic [DAC_BITS-1:0]   level_ff, level_in;
   logic [TIMER_BITS-1:0] tick_ff, tick_in;
   logic [ADC_BITS-1:0]   first_ff, first_in;
   logic [DAC_BITS-1:0]   held_ff, held_in;
   logic                  wr_evt, done_evt, point_evt;

   logic                  tick_last;
   logic [DAC_BITS-1:0]   step_eff;
   logic [DAC_BITS:0]     next_level;
   logic [DAC_BITS-1:0]   begin_lvl;
   logic                  begin_fits;
   logic [DAC_BITS-1:0]   high_code;

   logic [VPROD_W-1:0]        vprod;
   logic signed [31:0]        volt_wide;
   logic signed [ADC_BITS:0]  sdiff;
   logic signed [DPROD_W-1:0] dprod;
   logic signed [DQ_W-1:0]    dq;

   assign tick_last  = (tick_ff <= TIMER_BITS'(1));
   assign step_eff   = (step_code == '0) ? DAC_BITS'(1) : step_code;
   assign next_level = {1'b0, level_ff} + {1'b0, step_eff};
   assign high_code  = level_ff + amplitude_code;

   // Level that would begin on this transaction, and whether it plus the amplitude stays at or below stop.
   always_comb begin
      if (operation == OP_START) begin
         begin_lvl = start_code;
      end else if (phase_ff == PH_HIGH) begin
         begin_lvl = next_level[DAC_BITS-1:0];
      end else begin
         begin_lvl = level_ff;
      end
   end
   assign begin_fits = ({1'b0, begin_lvl} + {1'b0, amplitude_code}) <= {1'b0, stop_code};

   // Next-state logic.
   always_comb begin
      phase_in  = phase_ff;
      level_in  = level_ff;
      tick_in   = tick_ff;
      first_in  = first_ff;
      held_in   = held_ff;
      wr_evt    = 1'b0;
      done_evt  = 1'b0;
      point_evt = 1'b0;
      if (operation == OP_START) begin
         level_in = start_code;
         tick_in  = quiet_ticks;
         if (quiet_ticks == '0) begin
            if (begin_fits) begin
               phase_in = PH_LOW;
               tick_in  = low_ticks;
               held_in  = begin_lvl;
               wr_evt   = 1'b1;
            end else begin
               phase_in = PH_IDLE;
               done_evt = 1'b1;
            end
         end else begin
            phase_in = PH_QUIET;
         end
      end else begin
         case (phase_ff)
            PH_QUIET: begin
               if (tick_last) begin
                  tick_in = '0;
                  if (begin_fits) begin
                     phase_in = PH_LOW;
                     tick_in  = low_ticks;
                     held_in  = begin_lvl;
                     wr_evt   = 1'b1;
                  end else begin
                     phase_in = PH_IDLE;
                     done_evt = 1'b1;
                  end
               end else begin
                  tick_in = tick_ff - TIMER_BITS'(1);
               end
            end
            PH_LOW: begin
               if (tick_last) begin
                  first_in = adc_sample;
                  phase_in = PH_HIGH;
                  tick_in  = high_ticks;
                  held_in  = high_code;
                  wr_evt   = 1'b1;
               end else begin
                  tick_in = tick_ff - TIMER_BITS'(1);
               end
            end
            PH_HIGH: begin
               if (tick_last) begin
                  point_evt = 1'b1;
                  if (next_level[DAC_BITS]) begin
                     phase_in = PH_IDLE;
                     done_evt = 1'b1;
                  end else begin
                     level_in = next_level[DAC_BITS-1:0];
                     if (begin_fits) begin
                        phase_in = PH_LOW;
                        tick_in  = low_ticks;
                        held_in  = begin_lvl;
                        wr_evt   = 1'b1;
                     end else begin
                        phase_in = PH_IDLE;
                        done_evt = 1'b1;
                     end
                  end
               end else begin
                  tick_in = tick_ff - TIMER_BITS'(1);
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         level_ff <= '0;
         tick_ff  <= '0;
         held_ff  <= '0;
      end else if (proc_en) begin
         phase_ff <= phase_in;
         level_ff <= level_in;
         tick_ff  <= tick_in;
         held_ff  <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_en) begin
         first_ff <= first_in;
      end
   end

   // Point arithmetic. An arithmetic shift of the product gives the floor.
   assign vprod     = level_ff * VOLT_SCALE;
   assign volt_wide = VOLT_OFFSET - $signed({{(32-VQ_W){1'b0}}, vprod[VPROD_W-1:VOLT_SHIFT]});
   assign sdiff     = $signed({1'b0, first_ff}) - $signed({1'b0, adc_sample});
   assign dprod     = sdiff * $signed({1'b0, current_gain});
   assign dq        = dprod[DPROD_W-1:DIFF_SHIFT];

   // Result outputs.
   always_comb begin
      dac_code          = held_in;
      flags.dac_write   = wr_evt;
      flags.busy_res    = (phase_in != PH_IDLE);
      flags.point_valid = point_evt;
      flags.sweep_done  = done_evt;
      if (point_evt) begin
         step_voltage_mv    = volt_wide[VOLT_W-1:0];
         difference_current = {{(DIFF_W-DQ_W){dq[DQ_W-1]}}, dq};
      end else begin
         step_voltage_mv    = '0;
         difference_current = '0;
      end
   end

endmodule

[hdl/square_wave_voltammetry_sequencer.sv]
// A request transaction is registered when accepted, runs through the sequencer and
// lands in the response register once that register is free or being taken.
// Throughput: one transaction per cycle; requests stall only while a held
// response is not taken. Reset: synchronous, active high; clears the sweep (idle,
// level 0, DAC code 0), both pipeline valids and loads the register reset values.
// ----------------------------------------------------------------------------
// square_wave_voltammetry_sequencer
// Square wave voltammetry waveform sequencer with streaming request and
// response channels and a plain configuration write port.
// ----------------------------------------------------------------------------
module square_wave_voltammetry_sequencer
   import swv_pkg::*;
#(
   parameter int DAC_BITS   = 12,
   parameter int ADC_BITS   = 10,
   parameter int TIMER_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request: tdata = adc_sample; tuser = operation.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((ADC_BITS+7)/8)*8-1:0]        req_tdata,
   input  logic                                 req_tuser,
   // Response: tdata = dac_code, step_voltage_mv, difference_current.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((DAC_BITS+45+7)/8)*8-1:0]     rsp_tdata,
   // Response: tuser = dac_write, busy_res, point_valid, sweep_done.
   output logic [3:0]                           rsp_tuser,
   input  logic                                 csr_we,
   input  logic [CSR_ADDR_W-1:0]                csr_addr,
   input  logic [((DAC_BITS > TIMER_BITS) ? ((DAC_BITS > 24) ? DAC_BITS : 24)
                 : ((TIMER_BITS > 24) ? TIMER_BITS : 24))-1:0] csr_wdata
);

   localparam int CSR_W = (DAC_BITS > TIMER_BITS) ? ((DAC_BITS > 24) ? DAC_BITS : 24)
                          : ((TIMER_BITS > 24) ? TIMER_BITS : 24);
   localparam int OUT_W = ((DAC_BITS + VOLT_W + DIFF_W + 7) / 8) * 8;
   localparam int PAY_W = DAC_BITS + VOLT_W + DIFF_W;

   logic [DAC_BITS-1:0]   start_code, stop_code, step_code, amplitude_code;
   logic [TIMER_BITS-1:0] low_ticks, high_ticks, quiet_ticks;
   logic [GAIN_W-1:0]     current_gain;

   logic                  in_vld_ff, in_vld_in;
   logic                  in_op_ff;
   logic [ADC_BITS-1:0]   in_smp_ff;
   logic                  advance;

   logic                      out_vld_ff, out_vld_in;
   logic [PAY_W-1:0]          out_data_ff;
   swv_flags_type             out_flags_ff;

   logic [DAC_BITS-1:0]       dac_code;
   logic signed [VOLT_W-1:0]  step_voltage_mv;
   logic signed [DIFF_W-1:0]  difference_current;
   swv_flags_type             flags;

   swv_cfg #(
      .DAC_BITS   (DAC_BITS),
      .TIMER_BITS (TIMER_BITS),
      .CSR_W      (CSR_W)
   ) u_cfg (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .start_code     (start_code),
      .stop_code      (stop_code),
      .step_code      (step_code),
      .amplitude_code (amplitude_code),
      .low_ticks      (low_ticks),
      .high_ticks     (high_ticks),
      .quiet_ticks    (quiet_ticks),
      .current_gain   (current_gain)
   );

   // The held transaction moves into the response register when that is free or its response is being taken.
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_tvalid && req_tready) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff  <= req_tuser;
         in_smp_ff <= req_tdata[ADC_BITS-1:0];
      end
   end

   swv_seq #(
      .DAC_BITS   (DAC_BITS),
      .ADC_BITS   (ADC_BITS),
      .TIMER_BITS (TIMER_BITS)
   ) u_seq (
      .clock              (clock),
      .reset              (reset),
      .proc_en            (advance),
      .operation          (in_op_ff),
      .adc_sample         (in_smp_ff),
      .start_code         (start_code),
      .stop_code          (stop_code),
      .step_code          (step_code),
      .amplitude_code     (amplitude_code),
      .low_ticks          (low_ticks),
      .high_ticks         (high_ticks),
      .quiet_ticks        (quiet_ticks),
      .current_gain       (current_gain),
      .dac_code           (dac_code),
      .step_voltage_mv    (step_voltage_mv),
      .difference_current (difference_current),
      .flags              (flags)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff  <= {difference_current, step_voltage_mv, dac_code};
         out_flags_ff <= flags;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(OUT_W-PAY_W){1'b0}}, out_data_ff};
   assign rsp_tuser  = out_flags_ff;

endmodule

[hdl/swv_checker.sv]
// ----------------------------------------------------------------------------
// swv_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module swv_checker
   import swv_pkg::*;
#(
   parameter int DAC_BITS   = 12,
   parameter int ADC_BITS   = 10,
   parameter int TIMER_BITS = 16
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [((ADC_BITS+7)/8)*8-1:0]    req_tdata,
   input logic                             req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [((DAC_BITS+45+7)/8)*8-1:0] rsp_tdata,
   input logic [3:0]                       rsp_tuser
);

   localparam int PT_LO = DAC_BITS;
   localparam int PT_HI = DAC_BITS + VOLT_W + DIFF_W - 1;

   swv_flags_type rsp_flags;
   assign rsp_flags = rsp_tuser;

   // A response without a point carries zero voltage and current.
   a_no_point_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_flags.point_valid |-> rsp_tdata[PT_HI:PT_LO] == '0)
      else $error("point fields not zero without a point");

   // The sweep is never still busy on the transaction that finishes it.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_flags.sweep_done |-> !rsp_flags.busy_res)
      else $error("sweep_done while still busy");

   // The DAC is only written while a sweep runs.
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_flags.dac_write |-> rsp_flags.busy_res)
      else $error("dac_write outside a sweep");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser))
      else $error("stalled response changed");

   // No response can be offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind square_wave_voltammetry_sequencer swv_checker #(
   .DAC_BITS   (DAC_BITS),
   .ADC_BITS   (ADC_BITS),
   .TIMER_BITS (TIMER_BITS)
) u_swv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[sim/tb_square_wave_voltammetry_sequencer.sv]
// ----------------------------------------------------------------------------
// tb_square_wave_voltammetry_sequencer
// Self-checking bench for the square wave voltammetry sequencer. Request
// transactions come from a queue. A predictor of the sweep state machine
// computes each response when its request is accepted. The monitor compares
// every response transaction field by field with the oldest prediction.
// Register settings change only between sweeps, while the block is idle.
// ----------------------------------------------------------------------------
module tb_square_wave_voltammetry_sequencer;
   timeunit 1ns;
   timeprecision 1ps;
   import swv_pkg::*;

   localparam int CYCLE_LIMIT    = 1000000;
   localparam int DAC_TOP        = 4095;
   localparam int HOLD_MAX       = 65535;
   localparam int LONG_HOLD      = 40;
   localparam int STAGE_ITEMS    = 520;
   localparam int CELL_OFFSET_MV = 2346;
   localparam int MV_PER_CODE_Q10 = 1503;

   typedef struct packed {
      logic [11:0] start_code;
      logic [11:0] stop_code;
      logic [11:0] step_code;
      logic [11:0] amplitude_code;
      logic [15:0] low_ticks;
      logic [15:0] high_ticks;
      logic [15:0] quiet_ticks;
      logic [23:0] current_gain;
   } sweep_setting_type;

   typedef struct packed {
      logic       op;
      logic [9:0] adc;
      logic       pause_for_drain;
   } tick_item_type;

   typedef struct packed {
      logic [11:0]        dac_code;
      swv_flags_type      flags;
      logic signed [12:0] volt_mv;
      logic signed [31:0] diff_current;
   } sweep_output_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // adc_sample
   logic        req_tuser = 1'b0; // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // dac_code, step_voltage_mv, difference_current
   logic [3:0]  rsp_tuser;        // dac_write, busy_res, point_valid, sweep_done
   logic        csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [23:0] csr_wdata = '0;

   square_wave_voltammetry_sequencer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Predicted sequencer state and its register copy.
   sweep_setting_type setting = '{12'd0, 12'd4095, 12'd1, 12'd0, 16'd1, 16'd1, 16'd0,
                                  24'd11915};
   phase_type   sq_phase    = PH_IDLE;
   logic [11:0] level       = '0;
   logic [11:0] held_dac    = '0;
   logic [15:0] hold_count  = '0;
   logic [9:0]  first_adc   = '0;
   logic        dac_written = 1'b0;
   logic        sweep_ended = 1'b0;

   tick_item_type    tick_queue[$];
   sweep_output_type sweep_outputs_due[$];

   int unsigned req_gap_pct   = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned queued_total  = 0;
   int unsigned accepted_total = 0;
   int unsigned restarts      = 0;
   int unsigned points_checked = 0;
   int unsigned sweeps_finished = 0;
   int unsigned settings_used = 0;
   int unsigned errors        = 0;
   int unsigned cycle_count   = 0;

   // Enter the current level, or end the sweep when the level does not fit.
   function automatic void begin_level();
      if (int'(level) > int'(setting.stop_code) - int'(setting.amplitude_code)) begin
         sq_phase = PH_IDLE;
         sweep_ended = 1'b1;
      end else begin
         sq_phase = PH_LOW;
         hold_count = setting.low_ticks;
         held_dac = level;
         dac_written = 1'b1;
      end
   endfunction

   function automatic sweep_output_type advance_sweep(logic op, logic [9:0] adc);
      sweep_output_type r;
      longint prod;
      int nxt_level;
      int step_eff;
      r = '0;
      dac_written = 1'b0;
      sweep_ended = 1'b0;
      if (op == OP_START) begin
         level = setting.start_code;
         hold_count = setting.quiet_ticks;
         if (hold_count == 0) begin_level();
         else sq_phase = PH_QUIET;
      end else begin
         case (sq_phase)
            PH_QUIET: begin
               if (hold_count <= 1) begin
                  hold_count = '0;
                  begin_level();
               end else hold_count--;
            end
            PH_LOW: begin
               if (hold_count <= 1) begin
                  first_adc = adc;
                  sq_phase = PH_HIGH;
                  hold_count = setting.high_ticks;
                  held_dac = level + setting.amplitude_code;
                  dac_written = 1'b1;
               end else hold_count--;
            end
            PH_HIGH: begin
               if (hold_count <= 1) begin
                  // The arithmetic shift floors negative products.
                  prod = (longint'(first_adc) - longint'(adc)) * longint'(setting.current_gain);
                  r.diff_current = 32'(prod >>> 16);
                  r.volt_mv = 13'(CELL_OFFSET_MV - ((int'(level) * MV_PER_CODE_Q10) >>> 10));
                  r.flags.point_valid = 1'b1;
                  step_eff = (setting.step_code == 0) ? 1 : int'(setting.step_code);
                  nxt_level = int'(level) + step_eff;
                  if (nxt_level > DAC_TOP) begin
                     sq_phase = PH_IDLE;
                     sweep_ended = 1'b1;
                  end else begin
                     level = 12'(nxt_level);
                     begin_level();
                  end
               end else hold_count--;
            end
            default: sq_phase = PH_IDLE;
         endcase
      end
      r.dac_code = held_dac;
      r.flags.dac_write = dac_written;
      r.flags.busy_res = (sq_phase != PH_IDLE);
      r.flags.sweep_done = sweep_ended;
      return r;
   endfunction

   // Request driver: a transaction leaves the queue only when the bus is free.
   always @(posedge clock) begin : driver
      tick_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_START && sq_phase != PH_IDLE) restarts++;
            sweep_outputs_due.push_back(advance_sweep(req_tuser, req_tdata[9:0]));
            accepted_total++;
         end
         if (!req_tvalid || req_tready) begin
            if (tick_queue.size() != 0
                && !(tick_queue[0].pause_for_drain && sweep_outputs_due.size() != 0)
                && $urandom_range(99) >= req_gap_pct) begin
               nxt = tick_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {6'b0, nxt.adc};
               req_tuser <= nxt.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      sweep_output_type want;
      swv_flags_type got_flags;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (sweep_outputs_due.size() == 0) begin
               $error("response transaction arrived with nothing expected");
               errors++;
            end else begin
               want = sweep_outputs_due.pop_front();
               got_flags = rsp_tuser;
               check_field("dac_code", want.dac_code, rsp_tdata[11:0]);
               check_field("step_voltage_mv", want.volt_mv, $signed(rsp_tdata[24:12]));
               check_field("difference_current", want.diff_current,
                           $signed(rsp_tdata[56:25]));
               check_field("dac_write", want.flags.dac_write, got_flags.dac_write);
               check_field("busy_res", want.flags.busy_res, got_flags.busy_res);
               check_field("point_valid", want.flags.point_valid, got_flags.point_valid);
               check_field("sweep_done", want.flags.sweep_done, got_flags.sweep_done);
               if (want.flags.point_valid) points_checked++;
               if (want.flags.sweep_done) sweeps_finished++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_square_wave_voltammetry_sequencer: errors");
         $finish;
      end
   end

   function automatic void push_tick(logic op, logic [9:0] adc, logic pause);
      tick_queue.push_back('{op, adc, pause});
      queued_total++;
   endfunction

   function automatic logic [9:0] random_adc();
      case ($urandom_range(7))
         0: return 10'd0;
         1: return 10'd1023;
         default: return 10'($urandom_range(1023));
      endcase
   endfunction

   function automatic sweep_setting_type make_setting(int start, int stop, int step, int amp,
                                                      int low, int high, int quiet,
                                                      int unsigned gain);
      return '{12'(start), 12'(stop), 12'(step), 12'(amp),
               16'(low), 16'(high), 16'(quiet), 24'(gain)};
   endfunction

   function automatic int random_hold();
      return ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
   endfunction

   // Small staircases: a handful of levels at most, sometimes none that fit.
   function automatic sweep_setting_type random_setting();
      int amp, step, start, stop, eff, reach;
      int unsigned gain;
      amp = ($urandom_range(7) == 0) ? $urandom_range(4095) : $urandom_range(40);
      case ($urandom_range(7))
         0: step = 0;
         1: step = DAC_TOP;
         default: step = $urandom_range(1, 300);
      endcase
      start = ($urandom_range(3) == 0) ? $urandom_range(3800, 4095) : $urandom_range(4095);
      eff = (step == 0) ? 1 : step;
      if ($urandom_range(6) == 0) begin
         stop = (start + amp > 0) ? $urandom_range(start + amp - 1) : 0;
      end else begin
         reach = start + amp + eff * $urandom_range(5) + $urandom_range(eff - 1);
         stop = reach;
      end
      if (stop > DAC_TOP) stop = DAC_TOP;
      case ($urandom_range(5))
         0: gain = 0;
         1: gain = 24'hFFFFFF;
         default: gain = $urandom_range(24'hFFFFFF);
      endcase
      return make_setting(start, stop, step, amp, random_hold(), random_hold(),
                          $urandom_range(6), gain);
   endfunction

   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, logic [23:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
   endtask

   task automatic apply_setting(sweep_setting_type s);
      write_reg(REG_START, 24'(s.start_code));
      write_reg(REG_STOP, 24'(s.stop_code));
      write_reg(REG_STEP, 24'(s.step_code));
      write_reg(REG_AMPLITUDE, 24'(s.amplitude_code));
      write_reg(REG_LOW, 24'(s.low_ticks));
      write_reg(REG_HIGH, 24'(s.high_ticks));
      write_reg(REG_QUIET, 24'(s.quiet_ticks));
      write_reg(REG_GAIN, s.current_gain);
      @(posedge clock);
      csr_we <= 1'b0;
      setting = s;
      settings_used++;
   endtask

   task automatic wait_drained();
      while (accepted_total != queued_total || sweep_outputs_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One sweep with random content; a stray start now and then restarts it.
   task automatic run_random_sweep();
      int burst;
      apply_setting(random_setting());
      push_tick(OP_START, random_adc(), 1'b0);
      burst = $urandom_range(4, 40);
      for (int i = 0; i < burst; i++) begin
         if ($urandom_range(29) == 0) push_tick(OP_START, random_adc(), 1'b0);
         else push_tick(OP_TICK, random_adc(), $urandom_range(59) == 0);
      end
      wait_drained();
      while (sq_phase != PH_IDLE) begin
         for (int i = 0; i < 16; i++) push_tick(OP_TICK, random_adc(), 1'b0);
         wait_drained();
      end
   endtask

   initial begin : stimulus
      int unsigned stage_base;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      req_gap_pct = 22;
      rsp_stall_pct = 57;

      // Ticks straight out of reset leave the DAC code at zero.
      push_tick(OP_TICK, 10'd0, 1'b0);
      push_tick(OP_TICK, 10'd1023, 1'b0);
      wait_drained();

      // Top of the DAC range: the level after 4095 ends the sweep.
      apply_setting(make_setting(4093, 4095, 1, 0, 0, 0, 0, 24'hFFFFFF));
      push_tick(OP_START, 10'd0, 1'b0);
      push_tick(OP_TICK, 10'd1023, 1'b0);
      push_tick(OP_TICK, 10'd0, 1'b0);
      push_tick(OP_TICK, 10'd0, 1'b1);
      push_tick(OP_TICK, 10'd1023, 1'b0);
      push_tick(OP_TICK, 10'd512, 1'b0);
      push_tick(OP_TICK, 10'd511, 1'b0);
      push_tick(OP_TICK, 10'd300, 1'b0);
      wait_drained();

      // Zero step, full amplitude and a restart during the quiet wait.
      apply_setting(make_setting(0, 4095, 0, 4095, 1, 2, 2, 0));
      push_tick(OP_START, 10'd7, 1'b0);
      push_tick(OP_TICK, 10'd8, 1'b0);
      push_tick(OP_START, 10'd9, 1'b0);
      push_tick(OP_TICK, 10'd10, 1'b0);
      push_tick(OP_TICK, 10'd11, 1'b0);
      push_tick(OP_TICK, 10'd900, 1'b0);
      push_tick(OP_TICK, 10'd5, 1'b0);
      push_tick(OP_TICK, 10'd1, 1'b0);
      wait_drained();

      // Amplitude above stop, so no level fits.
      apply_setting(make_setting(4095, 0, 4095, 1, HOLD_MAX, HOLD_MAX, 0, 1));
      push_tick(OP_START, 10'd0, 1'b0);
      push_tick(OP_TICK, 10'd0, 1'b0);
      wait_drained();

      // Start above stop minus amplitude.
      apply_setting(make_setting(4095, 4094, 1, 0, 1, 1, 0, 12345));
      push_tick(OP_START, 10'd0, 1'b0);
      push_tick(OP_TICK, 10'd0, 1'b0);
      wait_drained();

      for (int stage = 0; stage < 3; stage++) begin
         req_gap_pct = (stage == 0) ? 22 : (stage == 1) ? 57 : 0;
         rsp_stall_pct = (stage == 0) ? 57 : (stage == 1) ? 22 : 0;
         stage_base = accepted_total;
         while (accepted_total - stage_base < STAGE_ITEMS) run_random_sweep();
      end

      // Longer quiet wait and hold times on a single level.
      apply_setting(make_setting(100, 100, 4095, 0, LONG_HOLD, LONG_HOLD, LONG_HOLD,
                                 24'hFFFFFF));
      push_tick(OP_START, random_adc(), 1'b0);
      for (int i = 0; i < 3 * LONG_HOLD; i++) push_tick(OP_TICK, random_adc(), 1'b0);
      wait_drained();
      repeat (10) @(posedge clock);

      $display("Checked %0d request transactions over %0d register settings.",
               accepted_total, settings_used);
      $display("Sweeps finished: %0d, points checked: %0d, restarts while busy: %0d.",
               sweeps_finished, points_checked, restarts);
      if (errors == 0) begin
         $display("tb_square_wave_voltammetry_sequencer: clean");
      end else begin
         $display("tb_square_wave_voltammetry_sequencer: errors");
      end
      $finish;
   end

endmodule
